// ----- sv/mvu_pkg.sv -----
// ----------------------------------------------------------------------------
// mvu_pkg: shared definitions for the int8 matrix-vector unit
// Register word map, control bits, widths and the cell command type.
// ----------------------------------------------------------------------------
package mvu_pkg;

   localparam int ACC_WIDTH_DEF = 32;
   localparam int ROWS          = 4;
   localparam int COLS          = 4;
   localparam int ELEM_W        = 8;
   localparam int IDX_W         = 4;
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * ELEM_W;
   localparam int SUM_W         = PROD_W + 2;
   localparam int REQ_TDATA_W   = 40;

   // register word indexes
   localparam logic [IDX_W-1:0] WORD_CTRL   = 4'd0;
   localparam logic [IDX_W-1:0] WORD_STATUS = 4'd1;
   localparam logic [IDX_W-1:0] WORD_WADDR  = 4'd2;
   localparam logic [IDX_W-1:0] WORD_WDATA  = 4'd3;
   localparam logic [IDX_W-1:0] WORD_XIN    = 4'd4;
   localparam logic [IDX_W-1:0] WORD_RES0   = 4'd8;
   localparam logic [IDX_W-1:0] WORD_RES1   = 4'd9;
   localparam logic [IDX_W-1:0] WORD_RES2   = 4'd10;
   localparam logic [IDX_W-1:0] WORD_RES3   = 4'd11;

   // CTRL bit positions
   localparam int CTRL_START_BIT = 0;
   localparam int CTRL_CLEAR_BIT = 4;

   // access kinds carried on tuser
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // command broadcast to every row cell
   typedef struct packed {
      logic                  wr_weight;
      logic [1:0]            row;
      logic [1:0]            col;
      logic [ELEM_W-1:0]     wdata;
      logic                  clear;
      logic                  start;
   } mvu_cell_cmd_type;

   // readback select, broadcast to every row cell
   typedef struct packed {
      logic                  sel;
      logic [1:0]            row;
   } mvu_rd_sel_type;

endpackage

// ----- sv/mvu_row_cell.sv -----
// ----------------------------------------------------------------------------
// mvu_row_cell: one row of the matrix-vector unit
// Holds four int8 weights and one accumulator; passes readback data along.
// ----------------------------------------------------------------------------
module mvu_row_cell import mvu_pkg::*; #(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF,
   parameter logic [1:0] ROW_ID = 2'd0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mvu_cell_cmd_type        cmd,
   input  logic [DATA_W-1:0]       x_vec,
   input  mvu_rd_sel_type          rd_sel,
   input  logic [DATA_W-1:0]       rd_in,
   output logic [DATA_W-1:0]       rd_out
);

   logic signed [ELEM_W-1:0]    w_ff [COLS];
   logic signed [ACC_WIDTH-1:0] acc_ff;
   logic signed [ACC_WIDTH-1:0] acc_in;
   logic signed [PROD_W-1:0]    prod [COLS];
   logic signed [SUM_W-1:0]     row_sum;
   logic signed [63:0]          acc_ext;

   always_comb begin
      for (int c = 0; c < COLS; c++) begin
         prod[c] = PROD_W'(w_ff[c]) * PROD_W'(signed'(x_vec[c*ELEM_W +: ELEM_W]));
      end
      row_sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
   end

   // clear acts before start when both are set
   always_comb begin
      acc_in = cmd.clear ? '0 : acc_ff;
      if (cmd.start) begin
         acc_in = acc_in + ACC_WIDTH'(row_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         for (int c = 0; c < COLS; c++) begin
            w_ff[c] <= '0;
         end
      end else begin
         acc_ff <= acc_in;
         if (cmd.wr_weight && cmd.row == ROW_ID) begin
            w_ff[cmd.col] <= cmd.wdata;
         end
      end
   end

   // sign-extend, keep low word, or pass the upstream value
   assign acc_ext = 64'(acc_ff);
   assign rd_out  = (rd_sel.sel && rd_sel.row == ROW_ID) ? acc_ext[DATA_W-1:0] : rd_in;

endmodule

// ----- sv/int8_matrix_vector_unit_regs_top.sv -----
// ----------------------------------------------------------------------------
// int8_matrix_vector_unit_regs_top: register-mapped 4x4 int8 matrix-vector unit
// A chain of four row cells, each with its weights and accumulator.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Ports                         Word contents
//  req      in   req_tvalid/tready/tdata/tuser one bus access (read or write)
//  rsp      out  rsp_tvalid/tready/tdata       read data, zero for writes
//
//  Flow: one word accepted per clock unless the response side stalls; the
//  response appears the next cycle. Each row cell does its four 8x8 products,
//  sum and accumulate combinationally into its accumulator register.
//  Reset: synchronous, active high; clears weights, pointer, X, accumulators,
//  done flag and the response valid flag.
//  Stalls: the response register is the only buffer; req_tready is high
//  while it is empty or being drained this cycle.
//
module int8_matrix_vector_unit_regs_top import mvu_pkg::*; #(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [3:0] word_index, [35:4] write_value, pad
   input  logic                   req_tuser,  // [0] command: 0 read, 1 write
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata   // [31:0] read_value
);

   logic                 accept;
   logic [IDX_W-1:0]     word_idx;
   logic [DATA_W-1:0]    wval;
   logic                 is_write;

   logic [IDX_W-1:0]     wptr_ff;
   logic [DATA_W-1:0]    xvec_ff;
   logic                 done_ff;
   logic                 done_in;
   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    rsp_data_ff;
   logic [DATA_W-1:0]    rd_value;

   mvu_cell_cmd_type     cmd;
   mvu_rd_sel_type       rd_sel;
   logic [DATA_W-1:0]    chain [ROWS+1];

   assign accept   = req_tvalid && req_tready;
   assign word_idx = req_tdata[IDX_W-1:0];
   assign wval     = req_tdata[IDX_W +: DATA_W];
   assign is_write = accept && (req_tuser == CMD_WRITE);

   // hold a word until taken, take a new one in the same cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // broadcast command to the row cells
   always_comb begin
      cmd.wr_weight = is_write && word_idx == WORD_WDATA;
      cmd.row       = wptr_ff[3:2];
      cmd.col       = wptr_ff[1:0];
      cmd.wdata     = wval[ELEM_W-1:0];
      cmd.clear     = is_write && word_idx == WORD_CTRL && wval[CTRL_CLEAR_BIT];
      cmd.start     = is_write && word_idx == WORD_CTRL && wval[CTRL_START_BIT];
      rd_sel.sel    = word_idx[3:2] == WORD_RES0[3:2];
      rd_sel.row    = word_idx[1:0];
   end

   assign chain[0] = '0;

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      mvu_row_cell #(
         .ACC_WIDTH (ACC_WIDTH),
         .ROW_ID    (2'(r))
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd),
         .x_vec  (xvec_ff),
         .rd_sel (rd_sel),
         .rd_in  (chain[r]),
         .rd_out (chain[r+1])
      );
   end

   // read decode; writes answer zero
   always_comb begin
      rd_value = '0;
      if (!is_write) begin
         unique case (word_idx) inside
            WORD_STATUS: rd_value = DATA_W'(done_ff);
            WORD_WADDR:  rd_value = DATA_W'(wptr_ff);
            WORD_XIN:    rd_value = xvec_ff;
            WORD_RES0, WORD_RES1, WORD_RES2, WORD_RES3: rd_value = chain[ROWS];
            default:     rd_value = '0;
         endcase
      end
   end

   // clear drops done, start sets it
   always_comb begin
      done_in = done_ff;
      if (cmd.clear) done_in = 1'b0;
      if (cmd.start) done_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         xvec_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (is_write && word_idx == WORD_WADDR) wptr_ff <= wval[IDX_W-1:0];
         if (is_write && word_idx == WORD_XIN)   xvec_ff <= wval;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rd_value;
      end
   end

endmodule

// ----- sv/mvu_port_checker.sv -----
// ----------------------------------------------------------------------------
// mvu_port_checker: port-level checks for the matrix-vector unit
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module mvu_port_checker import mvu_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [DATA_W-1:0]      rsp_tdata
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // every accepted write answers zero in the next cycle
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_WRITE
      |=> rsp_tvalid && rsp_tdata == '0)
      else $error("write access did not answer zero");

   // status read carries only the done bit
   a_status_bits: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_READ
      && req_tdata[IDX_W-1:0] == WORD_STATUS
      |=> rsp_tvalid && rsp_tdata[DATA_W-1:1] == '0)
      else $error("status read has stray bits");

   // weight pointer readback fits four bits
   a_waddr_bits: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_READ
      && req_tdata[IDX_W-1:0] == WORD_WADDR
      |=> rsp_tvalid && rsp_tdata[DATA_W-1:IDX_W] == '0)
      else $error("weight pointer readback too wide");

endmodule

bind int8_matrix_vector_unit_regs_top mvu_port_checker u_mvu_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/int8_mvu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_mvu_checker: response checker for the int8 matrix-vector unit
// Tracks weights, pointer, X and accumulators from every accepted request and
// compares each response word with the predicted read data, oldest first.
// ----------------------------------------------------------------------------
module int8_mvu_checker import mvu_pkg::*; #(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [3:0] word_index, [35:4] write_value, pad
   input  logic                   req_tuser,  // [0] command: 0 read, 1 write
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [DATA_W-1:0]      rsp_tdata,  // [31:0] read_value
   output int                     fail_count,
   output int                     pending_count,
   output int                     checked_count
);

   typedef struct {
      logic              cmd;
      logic [IDX_W-1:0]  word;
      logic [DATA_W-1:0] read_value;
   } read_expect_type;

   logic signed [ELEM_W-1:0] weights [ROWS*COLS];
   logic [IDX_W-1:0]         weight_ptr;
   logic [DATA_W-1:0]        x_vector;
   logic [ACC_WIDTH-1:0]     acc [ROWS];
   logic                     done;
   read_expect_type          read_value_q [$];

   // Apply one bus access to the tracked state and return its read data.
   function automatic logic [DATA_W-1:0] predict_read_value(
      input logic              cmd,
      input logic [IDX_W-1:0]  word,
      input logic [DATA_W-1:0] value
   );
      logic [DATA_W-1:0]           rd;
      int                          row_sum;
      logic signed [ACC_WIDTH-1:0] sum_ext;
      logic signed [63:0]          acc_ext;
      rd = '0;
      if (cmd == CMD_WRITE) begin
         case (word)
            WORD_CTRL: begin
               // clear acts first, so clear plus start lands on zeroed rows
               if (value[CTRL_CLEAR_BIT]) begin
                  foreach (acc[r]) acc[r] = '0;
                  done = 1'b0;
               end
               if (value[CTRL_START_BIT]) begin
                  for (int r = 0; r < ROWS; r++) begin
                     row_sum = 0;
                     for (int c = 0; c < COLS; c++)
                        row_sum += int'(weights[r*COLS+c]) *
                                   int'($signed(x_vector[c*ELEM_W +: ELEM_W]));
                     sum_ext = ACC_WIDTH'(row_sum);
                     acc[r]  = acc[r] + sum_ext;
                  end
                  done = 1'b1;
               end
            end
            WORD_WADDR: weight_ptr = value[IDX_W-1:0];
            WORD_WDATA: weights[weight_ptr] = value[ELEM_W-1:0];
            WORD_XIN:   x_vector = value;
            default: ;
         endcase
      end else begin
         case (word)
            WORD_STATUS: rd = {{(DATA_W-1){1'b0}}, done};
            WORD_WADDR:  rd = DATA_W'(weight_ptr);
            WORD_XIN:    rd = x_vector;
            WORD_RES0, WORD_RES1, WORD_RES2, WORD_RES3: begin
               acc_ext = 64'($signed(acc[word[1:0]]));
               rd      = acc_ext[DATA_W-1:0];
            end
            default: rd = '0;
         endcase
      end
      return rd;
   endfunction

   always @(posedge clock) begin : watch
      read_expect_type   oldest;
      logic [IDX_W-1:0]  word;
      logic [DATA_W-1:0] value;
      if (reset) begin
         foreach (weights[i]) weights[i] = '0;
         foreach (acc[r]) acc[r] = '0;
         weight_ptr = '0;
         x_vector   = '0;
         done       = 1'b0;
         read_value_q.delete();
      end else begin
         // the response leaving this edge always belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            if (read_value_q.size() == 0) begin
               $display("%0t: response %08h with no request outstanding", $time, rsp_tdata);
               fail_count++;
            end else begin
               oldest = read_value_q.pop_front();
               checked_count++;
               if (rsp_tdata !== oldest.read_value) begin
                  $display("%0t: %s word %0d: expected %08h, actual %08h", $time,
                           (oldest.cmd == CMD_WRITE) ? "write" : "read", oldest.word,
                           oldest.read_value, rsp_tdata);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            word  = req_tdata[IDX_W-1:0];
            value = req_tdata[IDX_W +: DATA_W];
            read_value_q.push_back('{req_tuser, word,
                                     predict_read_value(req_tuser, word, value)});
         end
      end
      pending_count = read_value_q.size();
   end

endmodule

// ----- verif/tb_int8_matrix_vector_unit_regs_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int8_matrix_vector_unit_regs_top: testbench for the int8 matrix-vector unit
// Directed register accesses, then random weight loads, vector loads, control
// writes and readbacks under varying request gaps and response stalls.
// ----------------------------------------------------------------------------
module tb_int8_matrix_vector_unit_regs_top;
   import mvu_pkg::*;

   localparam int RANDOM_ACCESSES = 700;
   localparam int PHASES          = 4;
   localparam int HOLD_CYCLES     = 80;
   localparam int QUIET_PERIOD    = 64;  // every period starts with a stretch of no idling
   localparam int QUIET_LEN       = 8;

   localparam logic [DATA_W-1:0] CTRL_START_WORD = DATA_W'(1) << CTRL_START_BIT;
   localparam logic [DATA_W-1:0] CTRL_CLEAR_WORD = DATA_W'(1) << CTRL_CLEAR_BIT;

   // holes in the register map
   localparam logic [IDX_W-1:0] WORD_HOLE_LO = 4'd7;
   localparam logic [IDX_W-1:0] WORD_HOLE_HI = 4'd15;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = CMD_READ;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;

   int fail_count;
   int pending_count;
   int checked_count;

   // knobs for the current phase, in percent of cycles
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request  = 0;  // cycles of response hold-off asked of the receiver

   int sent_count  = 0;
   int start_count = 0;

   int phase_send_pct [PHASES] = '{0, 45, 0, 30};
   int phase_rsp_pct  [PHASES] = '{0, 0, 45, 30};

   logic [IDX_W-1:0] readable_words [7] = '{WORD_STATUS, WORD_WADDR, WORD_XIN,
                                            WORD_RES0, WORD_RES1, WORD_RES2, WORD_RES3};

   always #1 clock = ~clock;

   int8_matrix_vector_unit_regs_top #(
      .ACC_WIDTH (ACC_WIDTH_DEF)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   int8_mvu_checker #(
      .ACC_WIDTH (ACC_WIDTH_DEF)
   ) u_mvu_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Response side: stall at random, or hold off entirely for a requested
   // number of cycles so the single response register fills and backs up
   // the request side.
   always @(negedge clock) begin : rsp_sink
      int hold_left;
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_request > 0) begin
         hold_left    = hold_request - 1;
         hold_request = 0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Offer one word from a falling edge and hold it until accepted. Afterwards
   // either leave valid high for a back-to-back word or drop it for a random
   // gap; valid never drops and rises in the same step.
   task automatic bus_access(input logic cmd, input logic [IDX_W-1:0] word,
                             input logic [DATA_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_TDATA_W-IDX_W-DATA_W){1'b0}}, value, word};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      if (cmd == CMD_WRITE && word == WORD_CTRL && value[CTRL_START_BIT])
         start_count++;
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_TDATA_W'({$urandom(), $urandom()});  // junk while idle
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
      end
   endtask

   // Drop valid and wait until every outstanding response has been checked.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      logic [DATA_W-1:0] wv;
      int                pick;
      bit                quiet;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // reset values
      bus_access(CMD_READ, WORD_STATUS, '1);
      bus_access(CMD_READ, WORD_RES3, '1);
      // pointer keeps only its low four bits
      bus_access(CMD_WRITE, WORD_WADDR, 32'hFFFF_FFF5);
      bus_access(CMD_READ, WORD_WADDR, '0);
      bus_access(CMD_WRITE, WORD_WDATA, 32'hFFFF_FF80);  // w[1][1] = -128
      bus_access(CMD_WRITE, WORD_WADDR, 32'h0000_0000);
      bus_access(CMD_WRITE, WORD_WDATA, 32'h1234_567F);  // w[0][0] = 127, upper bits dropped
      bus_access(CMD_WRITE, WORD_XIN, 32'h8080_8080);    // every x at -128
      bus_access(CMD_READ, WORD_XIN, '0);
      // clear and start together: accumulate into zeroed rows
      bus_access(CMD_WRITE, WORD_CTRL, CTRL_CLEAR_WORD | CTRL_START_WORD);
      bus_access(CMD_READ, WORD_STATUS, '0);
      bus_access(CMD_READ, WORD_RES0, '0);               // negative, sign extension
      bus_access(CMD_READ, WORD_RES1, '0);
      // control write with every bit but clear and start: no effect
      bus_access(CMD_WRITE, WORD_CTRL, ~(CTRL_CLEAR_WORD | CTRL_START_WORD));
      bus_access(CMD_WRITE, WORD_CTRL, CTRL_START_WORD);
      bus_access(CMD_READ, WORD_RES1, '0);
      // clear alone drops done and the accumulators
      bus_access(CMD_WRITE, WORD_CTRL, CTRL_CLEAR_WORD);
      bus_access(CMD_READ, WORD_STATUS, '0);
      // writes to read-only and unmapped words are ignored
      bus_access(CMD_WRITE, WORD_STATUS, '1);
      bus_access(CMD_WRITE, WORD_RES2, '1);
      bus_access(CMD_WRITE, WORD_HOLE_HI, '1);
      // words that always read zero
      bus_access(CMD_READ, WORD_CTRL, '1);
      bus_access(CMD_READ, WORD_WDATA, '1);
      bus_access(CMD_READ, WORD_HOLE_LO, '1);
      bus_access(CMD_READ, WORD_HOLE_HI, '1);
      wait_drained();

      // ---- random part, one phase per idle/stall setting ----
      for (int phase = 0; phase < PHASES; phase++) begin
         for (int n = 0; n < RANDOM_ACCESSES / PHASES; n++) begin
            quiet         = (n % QUIET_PERIOD) < QUIET_LEN;
            send_idle_pct = quiet ? 0 : phase_send_pct[phase];
            rsp_stall_pct = quiet ? 0 : phase_rsp_pct[phase];
            // long receiver hold-off while the sender keeps offering words
            if (phase == 0 && n == 100)
               hold_request = HOLD_CYCLES;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               // weight load: pointer then data, stray bits in both
               bus_access(CMD_WRITE, WORD_WADDR, $urandom());
               wv = $urandom();
               if ($urandom_range(0, 3) == 0)
                  wv[ELEM_W-1:0] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
               bus_access(CMD_WRITE, WORD_WDATA, wv);
            end else if (pick < 42) begin
               // vector load, some lanes at the extremes
               wv = $urandom();
               for (int c = 0; c < COLS; c++)
                  if ($urandom_range(0, 3) == 0)
                     wv[c*ELEM_W +: ELEM_W] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
               bus_access(CMD_WRITE, WORD_XIN, wv);
            end else if (pick < 57) begin
               // control: mostly starts, some clears, both, neither, raw
               wv = $urandom();
               case ($urandom_range(0, 5))
                  0, 1: begin
                     wv[CTRL_START_BIT] = 1'b1;
                     wv[CTRL_CLEAR_BIT] = 1'b0;
                  end
                  2: begin
                     wv[CTRL_START_BIT] = 1'b0;
                     wv[CTRL_CLEAR_BIT] = 1'b1;
                  end
                  3: begin
                     wv[CTRL_START_BIT] = 1'b1;
                     wv[CTRL_CLEAR_BIT] = 1'b1;
                  end
                  4: begin
                     wv[CTRL_START_BIT] = 1'b0;
                     wv[CTRL_CLEAR_BIT] = 1'b0;
                  end
                  default: ;
               endcase
               bus_access(CMD_WRITE, WORD_CTRL, wv);
            end else if (pick < 85) begin
               bus_access(CMD_READ, readable_words[$urandom_range(0, 6)], $urandom());
            end else begin
               // noise: any command to any word
               bus_access(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 15)),
                          $urandom());
            end
         end
         // sender pause until every response is back
         wait_drained();
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_drained();
      repeat (4) @(negedge clock);

      $display("Sent %0d register accesses (%0d starts) over four gap/stall phases", sent_count,
               start_count);
      $display("with one long response hold-off; %0d responses checked, %0d mismatches",
               checked_count, fail_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #400000;
      $display("Timed out with %0d responses outstanding", pending_count);
      $display("FAILURE");
      $finish;
   end

endmodule
